[hdl/gww_pkg.sv]
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types, constants and helpers for the word-wrap row breaker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

  localparam int POS_W      = 16;
  localparam int PEN_W      = 24;
  localparam int ADV_W      = 16;
  localparam int FUNC_W     = 3;
  localparam int LEN_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [POS_W-1:0] TEXT_BYTES = 16'hFFFF;
  localparam logic [PEN_W-1:0] PEN_MAX    = {PEN_W{1'b1}};

  localparam logic             WRAP_ENABLE_RST = 1'b1;
  localparam logic [PEN_W-1:0] WRAP_LIMIT_RST  = 24'd12288;
  localparam logic [ADV_W-1:0] SPACE_WIDTH_RST = 16'd256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GLYPH   = 3'd0,
    FUNC_SPACE   = 3'd1,
    FUNC_NEWLINE = 3'd2,
    FUNC_SKIP    = 3'd3,
    FUNC_END     = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_ENABLE = 2'd0,
    REG_WRAP_LIMIT  = 2'd1,
    REG_SPACE_WIDTH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             wrap_enable;
    logic [PEN_W-1:0] wrap_limit;
    logic [ADV_W-1:0] space_width;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LEN_W-1:0]  byte_len;
    logic [ADV_W-1:0]  advance;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] open_row_start;
    logic [PEN_W-1:0] pen_x;
    logic [POS_W-1:0] space_pos;
    logic             space_valid;
    logic [PEN_W-1:0] x_at_space;
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] row_start;
    logic [POS_W-1:0] row_end;
    logic [PEN_W-1:0] row_width;
    logic             final_row;
  } row_t;

  function automatic logic [POS_W-1:0] pos_sat(input logic [POS_W:0] v);
    if (v > {1'b0, TEXT_BYTES}) begin
      return TEXT_BYTES;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic [PEN_W-1:0] pen_sat(input logic [PEN_W:0] v);
    if (v > {1'b0, PEN_MAX}) begin
      return PEN_MAX;
    end
    return v[PEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/gww_step.sv]
// ----------------------------------------------------------------------------
// gww_step
// Next-state and row result for one text item against the open row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gww_step (
  input  wire gww_pkg::cfg_t   cfg,
  input  wire gww_pkg::item_t  item,
  input  wire gww_pkg::state_t state,
  output gww_pkg::state_t      state_next,
  output logic                 row_valid,
  output gww_pkg::row_t        row
);

  logic                       is_space;
  logic [gww_pkg::PEN_W:0]    w_ext;
  logic [gww_pkg::PEN_W-1:0]  next_pen;
  logic                       overflow;
  logic [gww_pkg::POS_W-1:0]  pos_adv;
  logic [gww_pkg::PEN_W:0]    sub;
  logic [gww_pkg::PEN_W:0]    next_ext;
  logic [gww_pkg::PEN_W-1:0]  carry;

  assign is_space = (item.func == gww_pkg::FUNC_SPACE);
  assign w_ext = is_space
               ? {{(gww_pkg::PEN_W + 1 - gww_pkg::ADV_W){1'b0}}, cfg.space_width}
               : {{(gww_pkg::PEN_W + 1 - gww_pkg::ADV_W){1'b0}}, item.advance};
  assign next_pen = gww_pkg::pen_sat({1'b0, state.pen_x} + w_ext);
  assign overflow = cfg.wrap_enable && (state.open_row_start < state.byte_pos)
                 && (next_pen > cfg.wrap_limit);
  assign pos_adv = gww_pkg::pos_sat({1'b0, state.byte_pos}
                 + {{(gww_pkg::POS_W + 1 - gww_pkg::LEN_W){1'b0}}, item.byte_len});
  assign sub = {1'b0, state.x_at_space}
             + {{(gww_pkg::PEN_W + 1 - gww_pkg::ADV_W){1'b0}}, cfg.space_width};
  assign next_ext = {1'b0, next_pen};
  assign carry = (next_ext > sub) ? gww_pkg::PEN_W'(next_ext - sub) : '0;

  always_comb begin
    state_next    = state;
    row_valid     = 1'b0;
    row.row_start = state.open_row_start;
    row.row_end   = state.byte_pos;
    row.row_width = state.pen_x;
    row.final_row = 1'b0;
    case (item.func) inside
      gww_pkg::FUNC_END: begin
        row_valid     = 1'b1;
        row.final_row = 1'b1;
        state_next    = '0;
      end
      gww_pkg::FUNC_SKIP: begin
        state_next.byte_pos = pos_adv;
      end
      gww_pkg::FUNC_NEWLINE: begin
        row_valid                 = 1'b1;
        state_next.byte_pos       = pos_adv;
        state_next.open_row_start = pos_adv;
        state_next.pen_x          = '0;
        state_next.space_valid    = 1'b0;
      end
      gww_pkg::FUNC_GLYPH, gww_pkg::FUNC_SPACE: begin
        state_next.byte_pos = pos_adv;
        if (overflow && state.space_valid && (state.space_pos > state.open_row_start)) begin
          // cut at the last space, surplus carries to the new row
          row_valid                 = 1'b1;
          row.row_end               = state.space_pos;
          row.row_width             = state.x_at_space;
          state_next.open_row_start = gww_pkg::pos_sat({1'b0, state.space_pos}
                                    + {{gww_pkg::POS_W{1'b0}}, 1'b1});
          state_next.pen_x          = carry;
          state_next.space_valid    = 1'b0;
        end else if (overflow) begin
          // hard cut before the item
          row_valid                 = 1'b1;
          state_next.open_row_start = state.byte_pos;
          state_next.pen_x          = w_ext[gww_pkg::PEN_W-1:0];
          if (is_space) begin
            state_next.space_pos   = state.byte_pos;
            state_next.space_valid = 1'b1;
            state_next.x_at_space  = '0;
          end
        end else begin
          state_next.pen_x = next_pen;
          if (is_space) begin
            state_next.space_pos   = state.byte_pos;
            state_next.space_valid = 1'b1;
            state_next.x_at_space  = state.pen_x;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/greedy_word_wrap_row_breaker.sv]
// ----------------------------------------------------------------------------
// greedy_word_wrap_row_breaker
// Cuts a stream of decoded text items into visual rows with greedy wrapping.
// ----------------------------------------------------------------------------
// A row passes through the input register, then the row register, before it is
// valid on the output; an output stall can hold it in the input register.
// Throughput: one item per cycle while the output is not stalled; the open-row state
// is registered from the step logic, and output stall backs up through the input register.
// Reset: rst loads the register defaults and clears the row state; no sweep.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_row_breaker (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [gww_pkg::FUNC_W-1:0]       func,
  input  wire  [gww_pkg::LEN_W-1:0]        byte_len,
  input  wire  [gww_pkg::ADV_W-1:0]        advance,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [gww_pkg::POS_W-1:0]        row_start,
  output logic [gww_pkg::POS_W-1:0]        row_end,
  output logic [gww_pkg::PEN_W-1:0]        row_width,
  output logic                             final_row,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [gww_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gww_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gww_pkg::cfg_t   cfg;
  gww_pkg::state_t state;
  gww_pkg::state_t state_next;
  gww_pkg::item_t  s1_item;
  logic            s1_valid;
  logic            row_valid;
  gww_pkg::row_t   row;
  logic            advance_ok;

  assign cfg_ready  = 1'b1;
  assign advance_ok = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !advance_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_enable <= gww_pkg::WRAP_ENABLE_RST;
      cfg.wrap_limit  <= gww_pkg::WRAP_LIMIT_RST;
      cfg.space_width <= gww_pkg::SPACE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gww_pkg::REG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        gww_pkg::REG_WRAP_LIMIT:  cfg.wrap_limit  <= cfg_data[gww_pkg::PEN_W-1:0];
        gww_pkg::REG_SPACE_WIDTH: cfg.space_width <= cfg_data[gww_pkg::ADV_W-1:0];
        default: ;
      endcase
    end
  end

  gww_step u_step (
    .cfg        (cfg),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .row_valid  (row_valid),
    .row        (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance_ok) begin
        out_valid <= s1_valid && row_valid;
      end
      if (advance_ok && s1_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.func     <= func;
      s1_item.byte_len <= byte_len;
      s1_item.advance  <= advance;
    end
    if (advance_ok && s1_valid && row_valid) begin
      row_start <= row.row_start;
      row_end   <= row.row_end;
      row_width <= row.row_width;
      final_row <= row.final_row;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stall without a blocked row");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance_ok) |=> (state == $past(state)))
    else $error("row state changed with no item processed");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance_ok && (s1_item.func == gww_pkg::FUNC_END))
    |=> (state == '0) && out_valid && final_row)
    else $error("end of text did not close and clear the text");

  a_final_only_end: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance_ok && row_valid && (s1_item.func != gww_pkg::FUNC_END))
    |=> out_valid && !final_row)
    else $error("final row flagged for a non-terminal item");

endmodule

`default_nettype wire

[bench/tb_greedy_word_wrap_row_breaker.sv]
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap_row_breaker
// Self-checking bench for the row breaker. A short table of text items with
// a few hand-written rows, then runs of random words, spaces, newlines and
// noise under several wrap settings, then long runs that saturate the pen.
// Every row is checked against an in-bench model of the greedy wrap, or against
// its hand-written row, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_word_wrap_row_breaker;

  localparam int RX_HOLD    = 64;
  localparam int SETTLE     = 8;
  localparam int WDOG_LIMIT = 2000;

  localparam logic [gww_pkg::FUNC_W-1:0] FUNC_RSV5 = 3'd5;
  localparam logic [gww_pkg::FUNC_W-1:0] FUNC_RSV6 = 3'd6;
  localparam logic [gww_pkg::FUNC_W-1:0] FUNC_RSV7 = 3'd7;

  typedef struct {
    logic [gww_pkg::FUNC_W-1:0] f;
    logic [gww_pkg::LEN_W-1:0]  len;
    logic [gww_pkg::ADV_W-1:0]  adv;
    bit                         typed_in;
    gww_pkg::row_t              row;
  } tab_row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [gww_pkg::FUNC_W-1:0]     func;
  logic [gww_pkg::LEN_W-1:0]      byte_len;
  logic [gww_pkg::ADV_W-1:0]      advance;
  logic                           out_valid;
  logic                           out_stall;
  logic [gww_pkg::POS_W-1:0]      row_start;
  logic [gww_pkg::POS_W-1:0]      row_end;
  logic [gww_pkg::PEN_W-1:0]      row_width;
  logic                           final_row;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [gww_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gww_pkg::CFG_DATA_W-1:0] cfg_data;

  // model copy of the registers and the open row
  logic                      cf_wrap_en  = gww_pkg::WRAP_ENABLE_RST;
  logic [gww_pkg::PEN_W-1:0] cf_limit    = gww_pkg::WRAP_LIMIT_RST;
  logic [gww_pkg::ADV_W-1:0] cf_space_w  = gww_pkg::SPACE_WIDTH_RST;
  logic [gww_pkg::POS_W-1:0] txt_pos     = '0;
  logic [gww_pkg::POS_W-1:0] row_open_at = '0;
  logic [gww_pkg::POS_W-1:0] brk_pos     = '0;
  logic [gww_pkg::PEN_W-1:0] pen         = '0;
  logic [gww_pkg::PEN_W-1:0] pen_at_brk  = '0;
  logic                      brk_ok      = 1'b0;

  gww_pkg::row_t rows_due[$];
  tab_row_t      stim_tab[$];
  bit            fix_now;
  gww_pkg::row_t fix_row;
  bit            steady;
  bit            rx_hold_req;
  int            errors = 0;
  int            idle_cycles = 0;

  greedy_word_wrap_row_breaker u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .byte_len  (byte_len),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_start (row_start),
    .row_end   (row_end),
    .row_width (row_width),
    .final_row (final_row),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [gww_pkg::POS_W-1:0] pos_plus(
      input logic [gww_pkg::POS_W-1:0] p, input logic [gww_pkg::LEN_W:0] n);
    logic [gww_pkg::POS_W:0] s;
    s = {1'b0, p} + n;
    return (s > {1'b0, gww_pkg::TEXT_BYTES}) ? gww_pkg::TEXT_BYTES
                                             : s[gww_pkg::POS_W-1:0];
  endfunction

  function automatic logic [gww_pkg::PEN_W-1:0] pen_plus(
      input logic [gww_pkg::PEN_W-1:0] a, input logic [gww_pkg::ADV_W-1:0] b);
    logic [gww_pkg::PEN_W:0] s;
    s = {1'b0, a} + b;
    return s[gww_pkg::PEN_W] ? gww_pkg::PEN_MAX : s[gww_pkg::PEN_W-1:0];
  endfunction

  task automatic predict_row_break(input logic [gww_pkg::FUNC_W-1:0] f,
                                   input logic [gww_pkg::LEN_W-1:0] len,
                                   input logic [gww_pkg::ADV_W-1:0] adv,
                                   output bit made, output gww_pkg::row_t row);
    logic [gww_pkg::ADV_W-1:0] w;
    logic [gww_pkg::PEN_W-1:0] nxt;
    logic [gww_pkg::PEN_W:0]   cut;
    bit                        sp;
    made = 1'b0;
    row = '0;
    if (f == gww_pkg::FUNC_END) begin
      row = '{row_open_at, txt_pos, pen, 1'b1};
      made = 1'b1;
      txt_pos = '0;
      row_open_at = '0;
      pen = '0;
      brk_pos = '0;
      brk_ok = 1'b0;
      pen_at_brk = '0;
    end else if (f == gww_pkg::FUNC_SKIP) begin
      txt_pos = pos_plus(txt_pos, len);
    end else if (f == gww_pkg::FUNC_NEWLINE) begin
      row = '{row_open_at, txt_pos, pen, 1'b0};
      made = 1'b1;
      txt_pos = pos_plus(txt_pos, len);
      row_open_at = txt_pos;
      pen = '0;
      brk_ok = 1'b0;
    end else if (f == gww_pkg::FUNC_GLYPH || f == gww_pkg::FUNC_SPACE) begin
      sp = (f == gww_pkg::FUNC_SPACE);
      w = sp ? cf_space_w : adv;
      nxt = pen_plus(pen, w);
      if (cf_wrap_en && row_open_at < txt_pos && nxt > cf_limit) begin
        made = 1'b1;
        if (brk_ok && brk_pos > row_open_at) begin
          // cut at the last space; the width past it moves to the new row
          cut = {1'b0, pen_at_brk} + cf_space_w;
          row = '{row_open_at, brk_pos, pen_at_brk, 1'b0};
          row_open_at = pos_plus(brk_pos, 3'd1);
          pen = ({1'b0, nxt} > cut) ? nxt - cut[gww_pkg::PEN_W-1:0] : '0;
          brk_ok = 1'b0;
        end else begin
          row = '{row_open_at, txt_pos, pen, 1'b0};
          row_open_at = txt_pos;
          if (sp) begin
            brk_pos = txt_pos;
            brk_ok = 1'b1;
            pen_at_brk = '0;
          end
          pen = gww_pkg::PEN_W'(w);
        end
      end else begin
        if (sp) begin
          brk_pos = txt_pos;
          brk_ok = 1'b1;
          pen_at_brk = pen;
        end
        pen = nxt;
      end
      txt_pos = pos_plus(txt_pos, len);
    end
  endtask

  task automatic cmp_field(input string name, input logic [gww_pkg::PEN_W-1:0] want,
                           input logic [gww_pkg::PEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : row_check
    gww_pkg::row_t want;
    gww_pkg::row_t seen;
    bit            made;
    if (rst === 1'b0) begin
      if (in_valid && !in_stall) begin
        predict_row_break(func, byte_len, advance, made, want);
        if (fix_now) begin
          want = fix_row;
          made = 1'b1;
        end
        if (made) rows_due.insert(rows_due.size(), want);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        seen = '{row_start, row_end, row_width, final_row};
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row, expected none, actual %0h..%0h w %0h f %0b",
                   $time, seen.row_start, seen.row_end, seen.row_width, seen.final_row);
          errors++;
        end else begin
          want = rows_due.pop_front();
          cmp_field("row_start", gww_pkg::PEN_W'(want.row_start),
                    gww_pkg::PEN_W'(seen.row_start));
          cmp_field("row_end", gww_pkg::PEN_W'(want.row_end),
                    gww_pkg::PEN_W'(seen.row_end));
          cmp_field("row_width", want.row_width, seen.row_width);
          cmp_field("final_row", gww_pkg::PEN_W'(want.final_row),
                    gww_pkg::PEN_W'(seen.final_row));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : rx_side
    int wait_n;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_stall = 1'b1;
        repeat (RX_HOLD) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      wait_n = steady ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_stall = 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      @(negedge clk);
    end
  end

  // called at a falling edge; valid stays high after the item is taken
  task automatic put_item(input logic [gww_pkg::FUNC_W-1:0] f,
                          input logic [gww_pkg::LEN_W-1:0] len,
                          input logic [gww_pkg::ADV_W-1:0] adv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = f;
    byte_len = len;
    advance = adv;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic settle_out();
    in_valid = 1'b0;
    while (rows_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input gww_pkg::reg_idx_t idx,
                           input logic [gww_pkg::CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      gww_pkg::REG_WRAP_ENABLE: cf_wrap_en = val[0];
      gww_pkg::REG_WRAP_LIMIT:  cf_limit = val[gww_pkg::PEN_W-1:0];
      gww_pkg::REG_SPACE_WIDTH: cf_space_w = val[gww_pkg::ADV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_step(input logic [gww_pkg::FUNC_W-1:0] f,
                          input logic [gww_pkg::LEN_W-1:0] len,
                          input logic [gww_pkg::ADV_W-1:0] adv, input bit typed_in,
                          input gww_pkg::row_t row);
    tab_row_t e;
    e = '{f, len, adv, typed_in, row};
    stim_tab.insert(stim_tab.size(), e);
  endtask

  function automatic logic [gww_pkg::ADV_W-1:0] glyph_advance();
    int unsigned top;
    top = cf_limit / 5;
    if (top < 16) top = 16;
    if (top > 65535) top = 65535;
    if ($urandom_range(0, 7) == 0) return gww_pkg::ADV_W'($urandom);
    return gww_pkg::ADV_W'($urandom_range(0, top));
  endfunction

  // words of glyphs split by spaces, with some newlines, ends, skips and noise
  task automatic send_prose(input int n);
    int sent;
    int wl;
    logic [gww_pkg::FUNC_W-1:0] f;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        f = gww_pkg::FUNC_W'($urandom_range(0, 7));
        put_item(f, gww_pkg::LEN_W'($urandom), gww_pkg::ADV_W'($urandom));
        if (f <= gww_pkg::FUNC_END) sent++;
      end else begin
        wl = $urandom_range(1, 8);
        repeat (wl) begin
          put_item(gww_pkg::FUNC_GLYPH, gww_pkg::LEN_W'($urandom_range(1, 3)),
                   glyph_advance());
        end
        sent += wl + 1;
        case ($urandom_range(0, 19))
          0: put_item(gww_pkg::FUNC_NEWLINE, 2'd1, gww_pkg::ADV_W'($urandom));
          1: put_item(gww_pkg::FUNC_END, 2'd0, '0);
          2: put_item(gww_pkg::FUNC_SKIP, gww_pkg::LEN_W'($urandom), '0);
          default: put_item(gww_pkg::FUNC_SPACE, 2'd1, '0);
        endcase
      end
    end
  endtask

  initial begin : tx_side
    logic                      en;
    logic [gww_pkg::PEN_W-1:0] lim;
    logic [gww_pkg::ADV_W-1:0] sw;
    rst = 1'b1;
    in_valid = 1'b0;
    func = gww_pkg::FUNC_GLYPH;
    byte_len = '0;
    advance = '0;
    cfg_valid = 1'b0;
    cfg_index = gww_pkg::REG_WRAP_ENABLE;
    cfg_data = '0;
    fix_now = 1'b0;
    fix_row = '0;
    steady = 1'b0;
    rx_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_step(gww_pkg::FUNC_END, 2'd0, 16'h0000, 1'b1, '{16'd0, 16'd0, 24'd0, 1'b1});
    add_step(gww_pkg::FUNC_GLYPH, 2'd1, 16'hFFFF, 1'b0, '0);
    add_step(gww_pkg::FUNC_NEWLINE, 2'd1, 16'h0000, 1'b1,
             '{16'd0, 16'd1, 24'h00FFFF, 1'b0});
    add_step(gww_pkg::FUNC_SPACE, 2'd1, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_GLYPH, 2'd3, 16'd12288, 1'b0, '0);
    add_step(gww_pkg::FUNC_SPACE, 2'd1, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_GLYPH, 2'd2, 16'd1000, 1'b0, '0);
    add_step(gww_pkg::FUNC_SPACE, 2'd1, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_GLYPH, 2'd1, 16'd11000, 1'b0, '0);
    add_step(gww_pkg::FUNC_SKIP, 2'd3, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_SKIP, 2'd0, 16'hFFFF, 1'b0, '0);
    add_step(FUNC_RSV5, 2'd3, 16'hFFFF, 1'b0, '0);
    add_step(FUNC_RSV7, 2'd2, 16'h1234, 1'b0, '0);
    add_step(gww_pkg::FUNC_GLYPH, 2'd0, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_NEWLINE, 2'd0, 16'h0000, 1'b0, '0);
    add_step(FUNC_RSV6, 2'd1, 16'h5555, 1'b0, '0);
    add_step(gww_pkg::FUNC_GLYPH, 2'd3, 16'hFFFF, 1'b0, '0);
    add_step(gww_pkg::FUNC_SKIP, 2'd2, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_END, 2'd0, 16'h0000, 1'b1,
             '{16'd14, 16'd19, 24'h00FFFF, 1'b1});
    add_step(gww_pkg::FUNC_SPACE, 2'd2, 16'hFFFF, 1'b0, '0);
    add_step(gww_pkg::FUNC_NEWLINE, 2'd1, 16'h0000, 1'b0, '0);
    add_step(gww_pkg::FUNC_END, 2'd3, 16'hAAAA, 1'b0, '0);
    foreach (stim_tab[i]) begin
      fix_now = stim_tab[i].typed_in;
      fix_row = stim_tab[i].row;
      put_item(stim_tab[i].f, stim_tab[i].len, stim_tab[i].adv);
    end
    fix_now = 1'b0;

    // carried width floors at zero once the space grows under an open row
    put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'd1000);
    put_item(gww_pkg::FUNC_SPACE, 2'd1, 16'h0000);
    put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'd100);
    settle_out();
    write_reg(gww_pkg::REG_SPACE_WIDTH, 24'h00FFFF);
    put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'd12000);
    put_item(gww_pkg::FUNC_END, 2'd0, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin en = 1'b1; lim = 24'd12288;  sw = 16'd256;   end
        1: begin en = 1'b1; lim = 24'd0;      sw = 16'd0;     end
        2: begin en = 1'b1; lim = 24'hFFFFFF; sw = 16'hFFFF;  end
        3: begin en = 1'b0; lim = 24'd12288;  sw = 16'd256;   end
        4: begin en = 1'b1; lim = 24'd4000;   sw = 16'd300;   end
        5: begin en = 1'b1; lim = 24'd65535;  sw = 16'hFFFF;  end
        6: begin en = 1'b1; lim = 24'd200;    sw = 16'd64;    end
        default: begin
          en = 1'($urandom_range(0, 1));
          lim = gww_pkg::PEN_W'($urandom_range(0, 100000));
          sw = gww_pkg::ADV_W'($urandom);
        end
      endcase
      settle_out();
      write_reg(gww_pkg::REG_WRAP_ENABLE, gww_pkg::CFG_DATA_W'(en));
      write_reg(gww_pkg::REG_WRAP_LIMIT, lim);
      write_reg(gww_pkg::REG_SPACE_WIDTH, gww_pkg::CFG_DATA_W'(sw));
      steady = (ph == 2 || ph == 5);
      if (ph == 1 || ph == 4) rx_hold_req = 1'b1;
      send_prose(135);
    end

    // pen saturation, first unwrapped, then a wrap cut from a saturated row
    steady = 1'b1;
    settle_out();
    write_reg(gww_pkg::REG_WRAP_ENABLE, '0);
    repeat (260) put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'hFFFF);
    put_item(gww_pkg::FUNC_NEWLINE, 2'd1, 16'h0000);
    settle_out();
    write_reg(gww_pkg::REG_WRAP_ENABLE, 24'd1);
    write_reg(gww_pkg::REG_WRAP_LIMIT, 24'hFFFFFE);
    write_reg(gww_pkg::REG_SPACE_WIDTH, 24'h0000FE);
    repeat (256) put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'hFFFF);
    put_item(gww_pkg::FUNC_SPACE, 2'd1, 16'h0000);
    put_item(gww_pkg::FUNC_GLYPH, 2'd1, 16'hFFFF);
    put_item(gww_pkg::FUNC_END, 2'd0, 16'h0000);

    settle_out();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
